### rtl/pwq_pkg.sv
// Package for the priority wait queue: sizes, request and status codes,
// sequencer states and the highest-set-bit function. No dependencies.
package pwq_pkg;
   localparam int NODES       = 32;
   localparam int PRIO_LEVELS = 32;
   localparam int NODE_W      = $clog2(NODES);
   localparam int LVL_W       = $clog2(PRIO_LEVELS);

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_CHOOSE = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_QUEUED   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_UNLINK,
      S_FIX,
      S_RESP
   } state_type;

   function automatic logic [LVL_W-1:0] top_level(input logic [PRIO_LEVELS-1:0] map);
      logic [LVL_W-1:0] r;
      r = '0;
      for (int i = 0; i < PRIO_LEVELS; i++) begin
         if (map[i]) begin
            r = LVL_W'(i);
         end
      end
      return r;
   endfunction
endpackage

### rtl/pwq_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module pwq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/priority_wait_queue_fifo_ties.sv
// Priority wait queue with first-in-first-out order within each level.
// Depends on pwq_pkg and pwq_ram.
// The response is valid after S_READ for an add, a failed request or the unused kind,
// and after S_UNLINK and S_FIX for a remove or choose that unlinks a node.
// One request in flight: a new request is taken only in S_IDLE, after the response has been
// accepted with rsp_tready; the link memories have a registered read.
// Reset is synchronous and clears the queued and non-empty flags and the sequencer.
module priority_wait_queue_fifo_ties (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // req_type[1:0], node_id[6:2], prio[11:7]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // status[1:0], chosen_node[6:2], chosen_prio[11:7], now_empty[12]
);
   import pwq_pkg::*;

   state_type              state_ff, state_in;
   logic [1:0]             kind_ff, kind_in;
   logic [NODE_W-1:0]      node_ff, node_in;
   logic [LVL_W-1:0]       lvl_ff, lvl_in;
   logic [1:0]             stat_ff, stat_in;
   logic [NODES-1:0]       queued_ff, queued_in;
   logic [PRIO_LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [NODE_W-1:0]      head_ff [PRIO_LEVELS];
   logic [NODE_W-1:0]      tail_ff [PRIO_LEVELS];
   logic [NODE_W-1:0]      nx_ff, nx_in, pv_ff, pv_in;
   logic [12:0]            rsp_ff, rsp_in;

   // Per-node link memories.
   logic              nxt_we, prv_we, lvl_we;
   logic [NODE_W-1:0] nxt_wa, prv_wa, nxt_wd, prv_wd, rd_a;
   logic [NODE_W-1:0] nxt_rd, prv_rd;
   logic [LVL_W-1:0]  lvl_rd;

   pwq_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_next (
      .clock, .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(rd_a), .rd_data(nxt_rd));
   pwq_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_prev (
      .clock, .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_addr(rd_a), .rd_data(prv_rd));
   pwq_ram #(.WIDTH(LVL_W), .DEPTH(NODES)) u_level (
      .clock, .wr_en(lvl_we), .wr_addr(node_ff), .wr_data(lvl_ff),
      .rd_addr(rd_a), .rd_data(lvl_rd));

   logic              hd_we, tl_we;
   logic [LVL_W-1:0]  hd_a, tl_a;
   logic [NODE_W-1:0] hd_d, tl_d;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {3'b0, rsp_ff};
   // The read address follows the node being loaded, so that a choose reads its head.
   assign rd_a       = node_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         queued_ff   <= '0;
         nonempty_ff <= '0;
      end else begin
         state_ff    <= state_in;
         queued_ff   <= queued_in;
         nonempty_ff <= nonempty_in;
      end
      kind_ff <= kind_in;
      node_ff <= node_in;
      lvl_ff  <= lvl_in;
      stat_ff <= stat_in;
      nx_ff   <= nx_in;
      pv_ff   <= pv_in;
      rsp_ff  <= rsp_in;
      if (hd_we) head_ff[hd_a] <= hd_d;
      if (tl_we) tail_ff[tl_a] <= tl_d;
   end

   always_comb begin
      logic is_head, is_tail;
      state_in    = state_ff;
      kind_in     = kind_ff;
      node_in     = node_ff;
      lvl_in      = lvl_ff;
      stat_in     = stat_ff;
      queued_in   = queued_ff;
      nonempty_in = nonempty_ff;
      nx_in       = nx_ff;
      pv_in       = pv_ff;
      rsp_in      = rsp_ff;
      nxt_we = 1'b0; nxt_wa = node_ff; nxt_wd = node_ff;
      prv_we = 1'b0; prv_wa = node_ff; prv_wd = node_ff;
      lvl_we = 1'b0;
      hd_we  = 1'b0; hd_a = lvl_ff; hd_d = node_ff;
      tl_we  = 1'b0; tl_a = lvl_ff; tl_d = node_ff;
      is_head = (head_ff[lvl_ff] == node_ff);
      is_tail = (tail_ff[lvl_ff] == node_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tdata[1:0];
               node_in = req_tdata[6:2];
               lvl_in  = req_tdata[11:7];
               stat_in = ST_OK;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // Checks, add linking, or choice of the head for a choose request.
            state_in = S_RESP;
            case (kind_ff)
               REQ_ADD: begin
                  if (queued_ff[node_ff]) begin
                     stat_in = ST_QUEUED;
                  end else begin
                     queued_in[node_ff] = 1'b1;
                     lvl_we = 1'b1;
                     tl_we  = 1'b1;
                     if (nonempty_ff[lvl_ff]) begin
                        nxt_we = 1'b1; nxt_wa = tail_ff[lvl_ff];
                        prv_we = 1'b1; prv_wd = tail_ff[lvl_ff];
                     end else begin
                        hd_we = 1'b1;
                        nonempty_in[lvl_ff] = 1'b1;
                     end
                  end
               end
               REQ_REMOVE: begin
                  if (!queued_ff[node_ff]) stat_in = ST_NOTFOUND;
                  else state_in = S_UNLINK;
               end
               REQ_CHOOSE: begin
                  if (nonempty_ff == '0) begin
                     stat_in = ST_EMPTY;
                  end else begin
                     lvl_in   = top_level(nonempty_ff);
                     node_in  = head_ff[top_level(nonempty_ff)];
                     state_in = S_UNLINK;
                  end
               end
               default: ;
            endcase
            if (state_in == S_RESP) begin
               rsp_in = {nonempty_in == '0, 5'd0, 5'd0, stat_in};
            end
         end
         S_UNLINK: begin
            // Link memories now hold this node's level and neighbours.
            nx_in = nxt_rd;
            pv_in = prv_rd;
            if (kind_ff == REQ_REMOVE) lvl_in = lvl_rd;
            state_in = S_FIX;
         end
         S_FIX: begin
            queued_in[node_ff] = 1'b0;
            if (is_head && is_tail) begin
               nonempty_in[lvl_ff] = 1'b0;
            end else if (is_head) begin
               hd_we = 1'b1; hd_d = nx_ff;
            end else if (is_tail) begin
               tl_we = 1'b1; tl_d = pv_ff;
            end else begin
               nxt_we = 1'b1; nxt_wa = pv_ff; nxt_wd = nx_ff;
               prv_we = 1'b1; prv_wa = nx_ff; prv_wd = pv_ff;
            end
            if (kind_ff == REQ_CHOOSE) begin
               rsp_in = {nonempty_in == '0, lvl_ff, node_ff, ST_OK};
            end else begin
               rsp_in = {nonempty_in == '0, 5'd0, 5'd0, ST_OK};
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_ff[12] == (nonempty_ff == '0)))
      else $error("now_empty disagrees with level bitmap");
   a_empty_nodes: assert property (@(posedge clock) disable iff (reset)
      (nonempty_ff == '0) |-> (queued_ff == '0))
      else $error("nodes queued while all levels empty");
   a_add_sets: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ && kind_ff == REQ_ADD && !queued_ff[node_ff])
      |=> queued_ff[$past(node_ff)] && nonempty_ff[$past(lvl_ff)])
      else $error("add did not mark node and level");
   a_choose_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ && kind_ff == REQ_CHOOSE && nonempty_ff != '0)
      |=> state_ff == S_UNLINK)
      else $error("choose on non-empty queue did not unlink");
endmodule
